/* src/loop_switcher_panel_scan_defines.svh */
// Assertion macros shared by the panel scan checker.
`ifndef LOOP_SWITCHER_PANEL_SCAN_DEFINES_SVH
`define LOOP_SWITCHER_PANEL_SCAN_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define LSPS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("panel scan check failed");

// Condition that must hold whenever a result is presented.
`define LSPS_ASSERT_OUT(lbl, cond) \
	`LSPS_ASSERT(lbl, out_valid |-> (cond))

`endif

/* src/lsps_pkg.sv */
// Shared types, thresholds and decode functions for the panel scan block.
package lsps_pkg;

	localparam int unsigned ADC_W   = 10;
	localparam int unsigned POS_W   = 3;
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned NUM_SEL = 4;

	typedef logic [ADC_W-1:0] adc_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_FFIRST = 2'd1,
		MODE_OFF    = 2'd2
	} mode_t;

	// Selector thresholds, strictly greater than
	localparam adc_t SEL_TH_BYP = 10'd1000;
	localparam adc_t SEL_TH_E   = 10'd700;
	localparam adc_t SEL_TH_D   = 10'd450;
	localparam adc_t SEL_TH_C   = 10'd250;
	localparam adc_t SEL_TH_B   = 10'd90;

	// Output switch thresholds, strictly greater than
	localparam adc_t OUT_TH_OFF  = 10'd1000;
	localparam adc_t OUT_TH_NORM = 10'd400;

	localparam pos_t POS_A      = 3'd0;
	localparam pos_t POS_B      = 3'd1;
	localparam pos_t POS_C      = 3'd2;
	localparam pos_t POS_D      = 3'd3;
	localparam pos_t POS_E      = 3'd4;
	localparam pos_t POS_BYPASS = 3'd5;

	localparam cnt_t COOLDOWN_RST = 8'd10;

	typedef struct packed {
		pos_t  [NUM_SEL-1:0] pos;
		mode_t               mode;
		logic                fb;
	} dec_t;

	typedef struct packed {
		logic  step;
		logic  fb;
		logic  input_on;
		mode_t mode;
	} ctrl_req_t;

	typedef struct packed {
		logic relay;
		logic input_led;
		logic output_led;
	} ctrl_rsp_t;

	function automatic pos_t quantize_sel(input adc_t v);
		pos_t p;
		if (v > SEL_TH_BYP)     p = POS_BYPASS;
		else if (v > SEL_TH_E)  p = POS_E;
		else if (v > SEL_TH_D)  p = POS_D;
		else if (v > SEL_TH_C)  p = POS_C;
		else if (v > SEL_TH_B)  p = POS_B;
		else                    p = POS_A;
		return p;
	endfunction

	function automatic mode_t decode_out(input adc_t v);
		mode_t m;
		if (v > OUT_TH_OFF)        m = MODE_OFF;
		else if (v > OUT_TH_NORM)  m = MODE_NORMAL;
		else                       m = MODE_FFIRST;
		return m;
	endfunction

endpackage

/* src/lsps_decode.sv */
// Selector and output switch decode with feedback loop detection.
module lsps_decode (
	input  lsps_pkg::adc_t sel1_adc,
	input  lsps_pkg::adc_t sel2_adc,
	input  lsps_pkg::adc_t sel3_adc,
	input  lsps_pkg::adc_t sel4_adc,
	input  lsps_pkg::adc_t output_adc,
	output lsps_pkg::dec_t dec
);
	import lsps_pkg::*;

	pos_t [NUM_SEL-1:0] pos;
	logic               fb;

	// Quantize each selector sample
	assign pos[0] = quantize_sel(sel1_adc);
	assign pos[1] = quantize_sel(sel2_adc);
	assign pos[2] = quantize_sel(sel3_adc);
	assign pos[3] = quantize_sel(sel4_adc);

	// Flag any two selectors on the same loop; bypass never counts
	always_comb begin
		fb = 1'b0;
		for (int i = 0; i < NUM_SEL; i++) begin
			for (int j = i + 1; j < NUM_SEL; j++) begin
				if (pos[i] == pos[j] && pos[i] != POS_BYPASS) begin
					fb = 1'b1;
				end
			end
		end
	end

	assign dec.pos  = pos;
	assign dec.mode = decode_out(output_adc);
	assign dec.fb   = fb;

endmodule

/* src/lsps_ctrl.sv */
// Tick phase, cooldown counter, kill relay state and LED blink logic.
module lsps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  lsps_pkg::cnt_t      cfg_wr_data,
	input  lsps_pkg::ctrl_req_t req,
	output lsps_pkg::ctrl_rsp_t rsp
);
	import lsps_pkg::*;

	cnt_t                cooldown_ticks_q;
	cnt_t                cooldown_q;
	logic [PHASE_W-1:0]  phase_q;
	logic                relay_q;
	cnt_t                cooldown_d;
	logic                relay_d;

	// Load on a killing fault, else run down, else release
	always_comb begin
		priority if (req.fb && !req.input_on) begin
			relay_d    = 1'b1;
			cooldown_d = cooldown_ticks_q;
		end else if (cooldown_q != '0) begin
			relay_d    = relay_q;
			cooldown_d = cooldown_q - 1'b1;
		end else begin
			relay_d    = 1'b0;
			cooldown_d = cooldown_q;
		end
	end

	// Hold the register and state; advance on each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_ticks_q <= COOLDOWN_RST;
			cooldown_q       <= '0;
			phase_q          <= '0;
			relay_q          <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cooldown_ticks_q <= cfg_wr_data;
			end
			if (req.step) begin
				cooldown_q <= cooldown_d;
				relay_q    <= relay_d;
				phase_q    <= phase_q + 1'b1;
			end
		end
	end

	// Drive the relay and blink LEDs from the phase before it advances
	always_comb begin
		rsp.relay     = relay_d;
		rsp.input_led = req.input_on | (req.fb & phase_q[1]);
		unique case (req.mode)
			MODE_OFF:    rsp.output_led = phase_q[0];
			MODE_FFIRST: rsp.output_led = 1'b1;
			MODE_NORMAL: rsp.output_led = 1'b0;
			default:     rsp.output_led = 1'b0;
		endcase
	end

endmodule

/* src/loop_switcher_panel_scan.sv */
// Loop switcher panel scan: one scan tick per request, decoded into switch state and LEDs.
// Each request is captured in an input register, decoded by short logic and written
// to a result register, so the block takes one request per clock; throughput is set
// only by output backpressure. Relay, cooldown and blink phase update when a tick moves
// into the result register, so ticks are processed strictly in order. cooldown_ticks
// (reset 10) is written via cfg_wr_en.
module loop_switcher_panel_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  lsps_pkg::cnt_t       cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lsps_pkg::adc_t       sel1_adc,
	input  lsps_pkg::adc_t       sel2_adc,
	input  lsps_pkg::adc_t       sel3_adc,
	input  lsps_pkg::adc_t       sel4_adc,
	input  lsps_pkg::adc_t       output_adc,
	input  logic                 input_pin,
	input  logic                 zloop1_pin,
	input  logic                 zloop2_pin,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 kill_relay,
	output logic                 input_led,
	output logic                 output_led,
	output logic                 zloop1_led,
	output logic                 zloop2_led,
	output logic                 feedback,
	output lsps_pkg::pos_t       sel1_pos,
	output lsps_pkg::pos_t       sel2_pos,
	output lsps_pkg::pos_t       sel3_pos,
	output lsps_pkg::pos_t       sel4_pos,
	output logic [1:0]           output_mode,
	output logic                 input_on
);
	import lsps_pkg::*;

	logic      valid_s1;
	adc_t      sel1_adc_s1, sel2_adc_s1, sel3_adc_s1, sel4_adc_s1, output_adc_s1;
	logic      input_pin_s1, zloop1_pin_s1, zloop2_pin_s1;
	logic      valid_s2;
	logic      kill_relay_s2, input_led_s2, output_led_s2;
	logic      zloop1_led_s2, zloop2_led_s2, feedback_s2, input_on_s2;
	pos_t      sel1_pos_s2, sel2_pos_s2, sel3_pos_s2, sel4_pos_s2;
	mode_t     mode_s2;
	logic      take_s2;
	logic      move_s1;
	logic      accept;
	dec_t      dec;
	ctrl_req_t creq;
	ctrl_rsp_t crsp;

	// Handshake: result register frees when empty or taken
	assign take_s2  = !valid_s2 || out_ready;
	assign move_s1  = valid_s1 && take_s2;
	assign in_ready = !valid_s1 || take_s2;
	assign accept   = in_valid && in_ready;

	// Track stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			sel1_adc_s1   <= sel1_adc;
			sel2_adc_s1   <= sel2_adc;
			sel3_adc_s1   <= sel3_adc;
			sel4_adc_s1   <= sel4_adc;
			output_adc_s1 <= output_adc;
			input_pin_s1  <= input_pin;
			zloop1_pin_s1 <= zloop1_pin;
			zloop2_pin_s1 <= zloop2_pin;
		end
	end

	lsps_decode u_decode (
		.sel1_adc   (sel1_adc_s1),
		.sel2_adc   (sel2_adc_s1),
		.sel3_adc   (sel3_adc_s1),
		.sel4_adc   (sel4_adc_s1),
		.output_adc (output_adc_s1),
		.dec        (dec)
	);

	assign creq.step     = move_s1;
	assign creq.fb       = dec.fb;
	assign creq.input_on = input_pin_s1;
	assign creq.mode     = dec.mode;

	lsps_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (creq),
		.rsp         (crsp)
	);

	// Load the result register
	always_ff @(posedge clk) begin
		if (move_s1) begin
			kill_relay_s2 <= crsp.relay;
			input_led_s2  <= crsp.input_led;
			output_led_s2 <= crsp.output_led;
			zloop1_led_s2 <= ~zloop1_pin_s1;
			zloop2_led_s2 <= ~zloop2_pin_s1;
			feedback_s2   <= dec.fb;
			sel1_pos_s2   <= dec.pos[0];
			sel2_pos_s2   <= dec.pos[1];
			sel3_pos_s2   <= dec.pos[2];
			sel4_pos_s2   <= dec.pos[3];
			mode_s2       <= dec.mode;
			input_on_s2   <= input_pin_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign kill_relay  = kill_relay_s2;
	assign input_led   = input_led_s2;
	assign output_led  = output_led_s2;
	assign zloop1_led  = zloop1_led_s2;
	assign zloop2_led  = zloop2_led_s2;
	assign feedback    = feedback_s2;
	assign sel1_pos    = sel1_pos_s2;
	assign sel2_pos    = sel2_pos_s2;
	assign sel3_pos    = sel3_pos_s2;
	assign sel4_pos    = sel4_pos_s2;
	assign output_mode = mode_s2;
	assign input_on    = input_on_s2;

endmodule

/* src/lsps_chk.sv */
// Port-level checker for the panel scan block, bound to the top level.
`include "loop_switcher_panel_scan_defines.svh"

module lsps_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 kill_relay,
	input logic                 input_led,
	input logic                 feedback,
	input lsps_pkg::pos_t       sel1_pos,
	input lsps_pkg::pos_t       sel2_pos,
	input lsps_pkg::pos_t       sel3_pos,
	input lsps_pkg::pos_t       sel4_pos,
	input logic                 input_on
);
	import lsps_pkg::*;

	logic fb_calc;

	// Recompute the fault from the shown positions
	assign fb_calc =
		(sel1_pos == sel2_pos && sel1_pos != POS_BYPASS) ||
		(sel1_pos == sel3_pos && sel1_pos != POS_BYPASS) ||
		(sel1_pos == sel4_pos && sel1_pos != POS_BYPASS) ||
		(sel2_pos == sel3_pos && sel2_pos != POS_BYPASS) ||
		(sel2_pos == sel4_pos && sel2_pos != POS_BYPASS) ||
		(sel3_pos == sel4_pos && sel3_pos != POS_BYPASS);

	// Hold a stalled result
	`LSPS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
	`LSPS_ASSERT_OUT(a_fb_match, feedback == fb_calc)
	`LSPS_ASSERT_OUT(a_kill_on_fault, !(feedback && !input_on) || kill_relay)
	`LSPS_ASSERT_OUT(a_led_input, !input_on || input_led)

endmodule

bind loop_switcher_panel_scan lsps_chk u_lsps_chk (.*);
